@@ src/scaled_matrix_multiply_accumulate_defines.svh @@
// Assertion macros shared by the checker of the scaled matrix multiply-accumulate block.
`ifndef SCALED_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define SCALED_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Property checked on every rising edge of clk_i, switched off while reset is held.
`define SMMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising edge of clk_i, reset included.
`define SMMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/smma_pkg.sv @@
// Package of types, codes and default sizes for the scaled matrix multiply-accumulate block.
`timescale 1ns / 1ps
`default_nettype none

package smma_pkg;

  // Default store dimensions.
  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned MAX_COLS_DEF  = 64;
  localparam int unsigned MAX_INNER_DEF = 64;

  // Configuration port widths and register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [6:0]         ROWS_USED_RST  = 7'd64;
  localparam logic [6:0]         COLS_USED_RST  = 7'd64;
  localparam logic [6:0]         INNER_LEN_RST  = 7'd64;
  localparam logic signed [15:0] ALPHA_GAIN_RST = 16'sd256;
  localparam logic signed [15:0] BETA_GAIN_RST  = 16'sd0;

  // Accumulator width.
  localparam int unsigned ACC_W = 40;

  // Function codes of an input word.
  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_LOAD_C  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SCALE,
    ST_SUM
  } state_e;

  // Input word.
  typedef struct packed {
    func_e              func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [15:0] result;
    logic               index_error;
  } out_word_t;

endpackage

`default_nettype wire

@@ src/smma_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module smma_ram #(
  parameter int unsigned DEPTH = smma_pkg::MAX_ROWS_DEF * smma_pkg::MAX_INNER_DEF,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/scaled_matrix_multiply_accumulate.sv @@
// Top level: C = alpha*A*B + beta*C, one C element per compute word.
// Load words write one element at the accepting edge, give no result and leave busy low.
// A compute word out of range strobes its error word in the next cycle, busy kept low.
// Otherwise busy rises and the block runs one multiply-accumulate term a cycle over k,
// the clamped inner length, then the drain, scaling and write-back; the result strobes
// as the element is written back to C and busy falls with it. No word is taken while busy.
// Reset restores the register defaults; the stores are not cleared. Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module scaled_matrix_multiply_accumulate #(
  parameter int unsigned MAX_ROWS  = smma_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = smma_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_INNER = smma_pkg::MAX_INNER_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire smma_pkg::in_word_t                   in_word_i,
  output logic                                      done_o,
  output smma_pkg::out_word_t                       out_word_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [smma_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [smma_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  import smma_pkg::*;

  localparam int unsigned A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int unsigned B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int unsigned C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned CAW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
  // Inner counter holds 0..MAX_INNER.
  localparam int unsigned KW = $clog2(MAX_INNER + 1);
  localparam int unsigned TOT_W = 57;

  // Configuration registers.
  logic [6:0]         rows_used_q, cols_used_q, inner_len_q;
  logic signed [15:0] alpha_gain_q, beta_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q  <= ROWS_USED_RST;
      cols_used_q  <= COLS_USED_RST;
      inner_len_q  <= INNER_LEN_RST;
      alpha_gain_q <= ALPHA_GAIN_RST;
      beta_gain_q  <= BETA_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_USED:  rows_used_q  <= cfg_wdata_i[6:0];
        REG_COLS_USED:  cols_used_q  <= cfg_wdata_i[6:0];
        REG_INNER_LEN:  inner_len_q  <= cfg_wdata_i[6:0];
        REG_ALPHA_GAIN: alpha_gain_q <= $signed(cfg_wdata_i);
        REG_BETA_GAIN:  beta_gain_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Acceptance and decode of the input word.
  logic accept, is_compute, idx_err, k_clamp_sel;
  logic [KW-1:0] k_eff;

  assign accept     = start && !busy;
  assign is_compute = (in_word_i.func == FUNC_COMPUTE);
  assign idx_err    = (32'(in_word_i.row) >= 32'(rows_used_q)) ||
                      (32'(in_word_i.row) >= MAX_ROWS) ||
                      (32'(in_word_i.col) >= 32'(cols_used_q)) ||
                      (32'(in_word_i.col) >= MAX_COLS);
  assign k_clamp_sel = (32'(inner_len_q) > MAX_INNER);
  assign k_eff       = k_clamp_sel ? KW'(MAX_INNER) : KW'(inner_len_q);

  // Sequencer and datapath registers.
  state_e state_q, state_d;
  logic [5:0]          row_q, col_q;
  logic [KW-1:0]       k_q, t_q;
  logic                v1_q, v2_q;
  logic signed [31:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [55:0]  alpha_prod_q;
  logic signed [31:0]  beta_prod_q;
  out_word_t           out_q;
  logic                done_q;

  logic issue, start_mac, wb;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_mac) state_d = ST_READ;
      ST_READ:  if (t_q >= k_q) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q && !v2_q) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy      = (state_q != ST_IDLE);
    start_mac = (state_q == ST_IDLE) && accept && is_compute && !idx_err;
    issue     = (state_q == ST_READ) && (t_q < k_q);
    wb        = (state_q == ST_SUM);
  end

  // Store ports.
  logic          a_we, b_we, c_we, c_re;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [15:0]    a_rdata, b_rdata, c_rdata, c_wdata;
  logic signed [15:0] res_sat;

  assign a_we = accept && (in_word_i.func == FUNC_LOAD_A) &&
                (32'(in_word_i.row) < MAX_ROWS) && (32'(in_word_i.col) < MAX_INNER);
  assign b_we = accept && (in_word_i.func == FUNC_LOAD_B) &&
                (32'(in_word_i.row) < MAX_INNER) && (32'(in_word_i.col) < MAX_COLS);
  assign a_waddr = AAW'(32'(in_word_i.row) * MAX_INNER + 32'(in_word_i.col));
  assign b_waddr = BAW'(32'(in_word_i.row) * MAX_COLS + 32'(in_word_i.col));
  assign a_raddr = AAW'(32'(row_q) * MAX_INNER + 32'(t_q));
  assign b_raddr = BAW'(32'(t_q) * MAX_COLS + 32'(col_q));

  // The C store takes loads from the input and the write-back of a computed element.
  assign c_we    = wb || (accept && (in_word_i.func == FUNC_LOAD_C) &&
                   (32'(in_word_i.row) < MAX_ROWS) && (32'(in_word_i.col) < MAX_COLS));
  assign c_waddr = wb ? CAW'(32'(row_q) * MAX_COLS + 32'(col_q))
                      : CAW'(32'(in_word_i.row) * MAX_COLS + 32'(in_word_i.col));
  assign c_wdata = wb ? res_sat : in_word_i.value;
  assign c_re    = start_mac;
  assign c_raddr = CAW'(32'(in_word_i.row) * MAX_COLS + 32'(in_word_i.col));

  smma_ram #(.DEPTH(A_DEPTH), .WIDTH(16), .AW(AAW)) u_a_store (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(in_word_i.value),
    .re_i(issue), .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  smma_ram #(.DEPTH(B_DEPTH), .WIDTH(16), .AW(BAW)) u_b_store (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(in_word_i.value),
    .re_i(issue), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  smma_ram #(.DEPTH(C_DEPTH), .WIDTH(16), .AW(CAW)) u_c_store (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  // Saturating accumulate of one product.
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    acc_sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - 32){prod_q[31]}}, prod_q};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // Final sum at Q.24, floor shift to Q8.8 and saturation to 16 bits.
  logic signed [TOT_W-1:0] total;
  logic signed [40:0]      shifted;

  always_comb begin
    total   = {alpha_prod_q[55], alpha_prod_q} + {{17{beta_prod_q[31]}}, beta_prod_q, 8'b0};
    shifted = total[TOT_W-1:16];
    if (shifted > 41'sd32767) begin
      res_sat = 16'sh7fff;
    end else if (shifted < -41'sd32768) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = shifted[15:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      done_q  <= wb || ((state_q == ST_IDLE) && accept && is_compute && idx_err);
      if (start_mac) begin
        t_q <= '0;
      end else if (issue) begin
        t_q <= t_q + KW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_mac) begin
      row_q <= in_word_i.row;
      col_q <= in_word_i.col;
      k_q   <= k_eff;
    end
    if (v1_q) begin
      prod_q <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (start_mac) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_next;
    end
    if (state_q == ST_SCALE) begin
      alpha_prod_q <= alpha_gain_q * acc_q;
      beta_prod_q  <= beta_gain_q * $signed(c_rdata);
    end
    if (wb) begin
      out_q.out_row     <= row_q;
      out_q.out_col     <= col_q;
      out_q.result      <= res_sat;
      out_q.index_error <= 1'b0;
    end else if ((state_q == ST_IDLE) && accept && is_compute && idx_err) begin
      out_q.out_row     <= in_word_i.row;
      out_q.out_col     <= in_word_i.col;
      out_q.result      <= '0;
      out_q.index_error <= 1'b1;
    end
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

endmodule

`default_nettype wire

@@ src/smma_checker.sv @@
// Port-level checker for the scaled matrix multiply-accumulate block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "scaled_matrix_multiply_accumulate_defines.svh"

module smma_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire smma_pkg::in_word_t  in_word_i,
  input wire logic                done_o,
  input wire smma_pkg::out_word_t out_word_o
);

  import smma_pkg::*;

  // A computed element is delivered in the cycle busy falls.
  `SMMA_ASSERT(a_fall_done, $fell(busy) |-> done_o, "busy fell without a result word")

  // A word with a valid index only follows a busy period.
  `SMMA_ASSERT(a_ok_after_busy, (done_o && !out_word_o.index_error) |-> $past(busy),
               "in-range result word without a preceding computation")

  // An index error answers a compute word accepted in the previous cycle.
  `SMMA_ASSERT(a_err_prompt, (done_o && out_word_o.index_error) |->
               $past(start && !busy && (in_word_i.func == FUNC_COMPUTE)),
               "index error word without a compute word before it")

  // A load word neither gives a result nor makes the block busy.
  `SMMA_ASSERT(a_load_quiet, (start && !busy && (in_word_i.func != FUNC_COMPUTE)) |=>
               (!done_o && !busy), "load word produced a result or busy")

endmodule

bind scaled_matrix_multiply_accumulate smma_checker u_smma_checker (.*);

`default_nettype wire
